// ===== sv/owsr_pkg.sv =====
`default_nettype none

package owsr_pkg;

   // field and state widths
   localparam int ENERGY_W   = 32;
   localparam int LEN_W      = 24;
   localparam int OFFSET_W   = 26;
   localparam int SUM_W      = 40;
   localparam int PROD_W     = ENERGY_W + LEN_W;
   localparam int QUOT_W     = 32;
   localparam int PIECE_W    = QUOT_W + 1;

   // register port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   localparam int MAX_SPLIT_DEF = 16;

   localparam logic [LEN_W-1:0] MONOMER_LENGTH_RST = 24'd229376;
   localparam logic [LEN_W-1:0] SEGMENT_LENGTH_RST = 24'd655360;

   typedef enum logic {
      REG_MONOMER_LENGTH = 1'b0,
      REG_SEGMENT_LENGTH = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEG_CHECK,
      ST_START,
      ST_TEST,
      ST_MUL,
      ST_DIV_WAIT,
      ST_ACC,
      ST_EMIT,
      ST_FINISH,
      ST_LAST
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic div_piece;
      logic seg_set;
      logic start;
      logic pick_loop;
      logic pick_tail;
      logic acc;
      logic emit;
      logic emit_last;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic loop_go;
      logic tail_go;
      logic tail;
      logic last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/owsr_if.sv =====
`default_nettype none

// input word channel
interface owsr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [owsr_pkg::ENERGY_W-1:0] energy;
   logic                                 final_item;

   modport source (output valid, energy, final_item, input ready);
   modport sink   (input valid, energy, final_item, output ready);
endinterface

// result word channel
interface owsr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [owsr_pkg::ENERGY_W-1:0] segment_energy;
   logic                                 final_result;

   modport source (output valid, segment_energy, final_result, input ready);
   modport sink   (input valid, segment_energy, final_result, output ready);
endinterface

`default_nettype wire

// ===== sv/owsr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Requires dividend < divisor * 2**QUOT_W and divisor != 0.
module owsr_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [owsr_pkg::PROD_W-1:0]   dividend,
   input  wire logic [owsr_pkg::LEN_W-1:0]    divisor,
   output logic                               done,
   output logic [owsr_pkg::QUOT_W-1:0]        quotient
);

   localparam int LW  = owsr_pkg::LEN_W;
   localparam int QW  = owsr_pkg::QUOT_W;
   localparam int CNT_W = $clog2(QW);

   logic [LW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [LW-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [LW:0] trial;
   logic [LW:0] diff;
   logic        ge;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[owsr_pkg::PROD_W-1:QW];
         quo_in  = dividend[QW-1:0];
         dsr_in  = divisor;
         cnt_in  = CNT_W'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[LW-1:0] : trial[LW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/owsr_csr.sv =====
`default_nettype none

// Configuration registers behind the APB-style port
module owsr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [owsr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [owsr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [owsr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready,
   output logic      [owsr_pkg::LEN_W-1:0]        monomer_length,
   output logic      [owsr_pkg::LEN_W-1:0]        segment_length
);

   localparam int LW = owsr_pkg::LEN_W;

   logic [LW-1:0] monomer_length_ff, monomer_length_in;
   logic [LW-1:0] segment_length_ff, segment_length_in;

   owsr_pkg::csr_reg_type reg_idx;
   logic                  wr_en;

   assign reg_idx = owsr_pkg::csr_reg_type'(paddr[owsr_pkg::CSR_IDX_BIT]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // write decode
   always_comb begin
      monomer_length_in = monomer_length_ff;
      segment_length_in = segment_length_ff;
      if (wr_en) begin
         unique case (reg_idx)
            owsr_pkg::REG_MONOMER_LENGTH: monomer_length_in = pwdata[LW-1:0];
            owsr_pkg::REG_SEGMENT_LENGTH: segment_length_in = pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         owsr_pkg::REG_MONOMER_LENGTH:
            prdata = owsr_pkg::CSR_DATA_W'(monomer_length_ff);
         owsr_pkg::REG_SEGMENT_LENGTH:
            prdata = owsr_pkg::CSR_DATA_W'(segment_length_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monomer_length_ff <= owsr_pkg::MONOMER_LENGTH_RST;
         segment_length_ff <= owsr_pkg::SEGMENT_LENGTH_RST;
      end else begin
         monomer_length_ff <= monomer_length_in;
         segment_length_ff <= segment_length_in;
      end
   end

   assign monomer_length = monomer_length_ff;
   assign segment_length = segment_length_ff;

endmodule

`default_nettype wire

// ===== sv/owsr_ctrl.sv =====
`default_nettype none

// Sequencer: one input word at a time, one piece per pass through the divider
module owsr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire owsr_pkg::status_type sts,
   output owsr_pkg::cmd_type         cmd
);

   owsr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= owsr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         owsr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = owsr_pkg::ST_SEG_CHECK;
            end
         end
         // effective segment length, at least ceil(monomer / MAX_SPLIT)
         owsr_pkg::ST_SEG_CHECK: begin
            cmd.seg_set = 1'b1;
            state_in    = owsr_pkg::ST_START;
         end
         owsr_pkg::ST_START: begin
            cmd.start = 1'b1;
            state_in  = owsr_pkg::ST_TEST;
         end
         // next piece: closing segment, tail of monomer, or nothing left
         owsr_pkg::ST_TEST: begin
            if (sts.loop_go) begin
               cmd.pick_loop = 1'b1;
               state_in      = owsr_pkg::ST_MUL;
            end else if (sts.tail_go) begin
               cmd.pick_tail = 1'b1;
               state_in      = owsr_pkg::ST_MUL;
            end else begin
               state_in = owsr_pkg::ST_FINISH;
            end
         end
         owsr_pkg::ST_MUL: begin
            cmd.div_piece = 1'b1;
            state_in      = owsr_pkg::ST_DIV_WAIT;
         end
         owsr_pkg::ST_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = owsr_pkg::ST_ACC;
            end
         end
         owsr_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.tail ? owsr_pkg::ST_FINISH : owsr_pkg::ST_EMIT;
         end
         owsr_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = owsr_pkg::ST_TEST;
            end
         end
         owsr_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = sts.last ? owsr_pkg::ST_LAST : owsr_pkg::ST_IDLE;
         end
         owsr_pkg::ST_LAST: begin
            if (sts.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = owsr_pkg::ST_IDLE;
            end
         end
         default: state_in = owsr_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/owsr_dp.sv =====
`default_nettype none

// Datapath: offsets, piece weighting (multiply + divide), running sum, result register
module owsr_dp #(
   parameter int MAX_SPLIT = owsr_pkg::MAX_SPLIT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire owsr_pkg::cmd_type                   cmd,
   output owsr_pkg::status_type                     sts,
   input  wire logic [owsr_pkg::LEN_W-1:0]          monomer_length,
   input  wire logic [owsr_pkg::LEN_W-1:0]          segment_length,
   input  wire logic signed [owsr_pkg::ENERGY_W-1:0] req_energy,
   input  wire logic                                req_final_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [owsr_pkg::ENERGY_W-1:0]     rsp_segment_energy,
   output logic                                     rsp_final_result
);

   localparam int LW  = owsr_pkg::LEN_W;
   localparam int EW  = owsr_pkg::ENERGY_W;
   localparam int OW  = owsr_pkg::OFFSET_W;
   localparam int SW  = owsr_pkg::SUM_W;
   localparam int PW  = owsr_pkg::PROD_W;
   localparam int QW  = owsr_pkg::QUOT_W;
   localparam int CW  = owsr_pkg::PIECE_W;
   localparam int N_W = $clog2(MAX_SPLIT + 1);

   // ceil(m / MAX_SPLIT) by reciprocal multiplication, exact for 25-bit numerators
   localparam int CLAMP_NUM_W = LW + 1;
   localparam int RECIP_SH    = CLAMP_NUM_W + $clog2(MAX_SPLIT);
   localparam int RECIP_W     = CLAMP_NUM_W + 1;
   localparam int CLAMP_PW    = RECIP_SH + LW;
   localparam longint RECIP_L =
      ((longint'(1) << RECIP_SH) + longint'(MAX_SPLIT) - longint'(1)) / longint'(MAX_SPLIT);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [EW-1:0] OUT_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] OUT_MIN = {1'b1, {(EW-1){1'b0}}};

   // item registers
   logic [LW-1:0]        m_ff, m_in;
   logic [LW-1:0]        s_ff, s_in;
   logic [LW-1:0]        seg_ff, seg_in;
   logic [EW-1:0]        abs_e_ff, abs_e_in;
   logic                 neg_ff, neg_in;
   logic                 last_ff, last_in;
   logic [LW-1:0]        width_ff, width_in;
   logic                 tail_ff, tail_in;
   // chain state
   logic signed [SW-1:0] psum_ff, psum_in;
   logic [OW-1:0]        seo_ff, seo_in;
   logic [LW-1:0]        pos_ff, pos_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic                 started_ff, started_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [EW-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CLAMP_NUM_W-1:0] clamp_num;
   logic [CLAMP_PW-1:0]    clamp_prod;
   logic [LW-1:0]          seg_floor;
   logic [PW-1:0]        div_dividend;
   logic [LW-1:0]        div_divisor;
   logic                 div_start;
   logic                 div_done;
   logic [QW-1:0]        div_quot;
   logic [EW-1:0]        e_raw;
   logic signed [CW-1:0] piece;
   logic signed [SW:0]   sum_wide;
   logic signed [SW-1:0] sum_sat;
   logic signed [EW-1:0] out_sat;
   logic                 out_free;

   // divider: piece weight
   assign div_start    = cmd.div_piece;
   assign div_dividend = PW'(width_ff) * PW'(abs_e_ff);
   assign div_divisor  = m_ff;

   owsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // shortest allowed segment: ceil(monomer / MAX_SPLIT)
   assign clamp_num  = CLAMP_NUM_W'(m_ff) + CLAMP_NUM_W'(MAX_SPLIT - 1);
   assign clamp_prod = CLAMP_PW'(clamp_num) * CLAMP_PW'(RECIP);
   assign seg_floor  = clamp_prod[RECIP_SH +: LW];

   // signed piece, running sum saturation, output saturation
   always_comb begin
      piece    = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
      sum_wide = $signed({psum_ff[SW-1], psum_ff}) + (SW+1)'(piece);
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_sat = sum_wide[SW] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SW-1:0];
      end
      if (psum_ff > SW'(OUT_MAX)) begin
         out_sat = OUT_MAX;
      end else if (psum_ff < SW'(OUT_MIN)) begin
         out_sat = OUT_MIN;
      end else begin
         out_sat = psum_ff[EW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign e_raw    = req_energy;

   // status to controller
   always_comb begin
      sts.div_done   = div_done;
      sts.loop_go    = (seo_ff < OW'(m_ff)) && (n_ff < N_W'(MAX_SPLIT));
      sts.tail_go    = (pos_ff < m_ff);
      sts.tail       = tail_ff;
      sts.last       = last_ff;
      sts.out_free   = out_free;
   end

   // next state
   always_comb begin
      m_in         = m_ff;
      s_in         = s_ff;
      seg_in       = seg_ff;
      abs_e_in     = abs_e_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      width_in     = width_ff;
      tail_in      = tail_ff;
      psum_in      = psum_ff;
      seo_in       = seo_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // latch word and registers; zero monomer length counts as one
      if (cmd.load) begin
         m_in     = (monomer_length == '0) ? LW'(1) : monomer_length;
         s_in     = segment_length;
         neg_in   = e_raw[EW-1];
         abs_e_in = e_raw[EW-1] ? (~e_raw + 1'b1) : e_raw;
         last_in  = req_final_item;
      end

      // short segment is raised to the floor
      if (cmd.seg_set) begin
         seg_in = (s_ff < seg_floor) ? seg_floor : s_ff;
      end

      // new item: reload offset at chain start
      if (cmd.start) begin
         if (!started_ff) begin
            seo_in     = OW'(seg_ff);
            started_in = 1'b1;
         end
         pos_in = '0;
         n_in   = '0;
      end

      if (cmd.pick_loop) begin
         width_in = seo_ff[LW-1:0] - pos_ff;
         tail_in  = 1'b0;
      end
      if (cmd.pick_tail) begin
         width_in = m_ff - pos_ff;
         tail_in  = 1'b1;
      end

      if (cmd.acc) begin
         psum_in = sum_sat;
      end

      // segment closes inside the monomer
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_sat;
         rsp_last_in  = 1'b0;
         psum_in      = '0;
         pos_in       = seo_ff[LW-1:0];
         seo_in       = seo_ff + OW'(seg_ff);
         n_in         = n_ff + 1'b1;
      end

      // rebase offset to the next monomer's start
      if (cmd.finish) begin
         seo_in = (seo_ff >= OW'(m_ff)) ? (seo_ff - OW'(m_ff)) : '0;
      end

      // trailing word of the chain
      if (cmd.emit_last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_sat;
         rsp_last_in  = 1'b1;
         psum_in      = '0;
         started_in   = 1'b0;
         seo_in       = OW'(seg_ff);
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      s_ff        <= s_in;
      seg_ff      <= seg_in;
      abs_e_ff    <= abs_e_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      width_ff    <= width_in;
      tail_ff     <= tail_in;
      pos_ff      <= pos_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         psum_ff      <= '0;
         seo_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         psum_ff      <= psum_in;
         seo_ff       <= seo_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_energy = rsp_data_ff;
   assign rsp_final_result   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/overlap_weighted_segment_rebinner_top.sv =====
// Re-bins a stream of per-monomer energies (signed Q15.16) into segments of
// segment_length (unsigned Q8.16); each monomer adds energy*overlap/monomer_length,
// truncated toward zero, to a 40-bit saturating sum, and a 32-bit saturated
// result word leaves each time a segment closes. An input word with final_item
// set always adds a trailing word with final_result set and restarts the chain.
// segment_length is raised to ceil(monomer_length/MAX_SPLIT) when shorter.
// One input word is processed at a time. Every weighted piece goes through a
// restoring divider that produces one quotient bit per cycle; a new result word
// waits until the output register is free or its word is taken on rsp_chan.ready.
// Input is accepted again as soon as the last word is placed in the output
// register, even while that word still waits on rsp_chan.ready.
// Registers: monomer_length at address 0, segment_length at address 4.
`default_nettype none

module overlap_weighted_segment_rebinner_top #(
   parameter int MAX_SPLIT = owsr_pkg::MAX_SPLIT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   owsr_req_if.sink                             req_chan,
   owsr_rsp_if.source                           rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [owsr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [owsr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [owsr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);

   logic [owsr_pkg::LEN_W-1:0] monomer_length;
   logic [owsr_pkg::LEN_W-1:0] segment_length;
   owsr_pkg::cmd_type          cmd;
   owsr_pkg::status_type       sts;
   logic                       req_ready;

   owsr_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .monomer_length (monomer_length),
      .segment_length (segment_length)
   );

   owsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   owsr_dp #(
      .MAX_SPLIT (MAX_SPLIT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .monomer_length     (monomer_length),
      .segment_length     (segment_length),
      .req_energy         (req_chan.energy),
      .req_final_item     (req_chan.final_item),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_segment_energy (rsp_chan.segment_energy),
      .rsp_final_result   (rsp_chan.final_result)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire

// ===== tb/overlap_weighted_segment_rebinner_top_test.sv =====
`timescale 1ns / 100ps

module overlap_weighted_segment_rebinner_top_test;

   localparam int  ENERGY_W       = owsr_pkg::ENERGY_W;
   localparam int  LEN_W          = owsr_pkg::LEN_W;
   localparam int  SUM_W          = owsr_pkg::SUM_W;
   localparam int  OFFSET_W       = owsr_pkg::OFFSET_W;
   localparam int  CSR_ADDR_W     = owsr_pkg::CSR_ADDR_W;
   localparam int  CSR_DATA_W     = owsr_pkg::CSR_DATA_W;
   localparam int  CSR_IDX_BIT    = owsr_pkg::CSR_IDX_BIT;

   localparam int  SPLIT_CAP      = owsr_pkg::MAX_SPLIT_DEF;
   // worst item: 16 closing pieces, tail piece, trailing word
   localparam int  SETTLE_CYCLES  = 800;
   localparam int  CYCLE_LIMIT    = 2000000;
   localparam int  RANDOM_PHASES  = 10;
   localparam int  PHASE_ITEMS    = 48;
   localparam int  STEADY_PHASE   = 4;
   localparam int  REPORT_MAX     = 10;

   localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
   localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
   localparam logic [LEN_W-1:0]           LEN_MAX    = {LEN_W{1'b1}};

   localparam longint SUM_HI  = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_LO  = -(longint'(1) << (SUM_W - 1));
   localparam longint WORD_HI = (longint'(1) << (ENERGY_W - 1)) - 1;
   localparam longint WORD_LO = -(longint'(1) << (ENERGY_W - 1));
   localparam longint OFFSET_MASK = (longint'(1) << OFFSET_W) - 1;

   typedef struct {
      logic signed [ENERGY_W-1:0] energy;
      logic                       final_item;
   } monomer_word_type;

   typedef struct {
      logic signed [ENERGY_W-1:0] energy;
      logic                       final_result;
   } segment_word_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   owsr_req_if req_if ();
   owsr_rsp_if rsp_if ();

   overlap_weighted_segment_rebinner_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   monomer_word_type monomer_backlog[$];
   segment_word_type expected_segments[$];
   segment_word_type oldest_segment;

   bit steady_flow = 1'b0;
   int mismatch_count = 0;
   int cycle_count = 0;

   // rebinner state as seen by the predictor
   logic [LEN_W-1:0] mono_len = owsr_pkg::MONOMER_LENGTH_RST;
   logic [LEN_W-1:0] seg_len = owsr_pkg::SEGMENT_LENGTH_RST;
   longint           run_sum = 0;
   longint           seg_end = 0;
   bit               chain_open = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // weighted piece into the 40-bit saturating sum
   task automatic add_share(input longint e, input longint w, input longint m);
      longint s;
      s = run_sum + (e * w) / m;
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      run_sum = s;
   endtask

   // saturate the open sum to one result word
   task automatic push_segment(input logic last);
      longint           v;
      segment_word_type word;
      v = run_sum;
      if (v > WORD_HI) v = WORD_HI;
      if (v < WORD_LO) v = WORD_LO;
      word.energy       = v[ENERGY_W-1:0];
      word.final_result = last;
      expected_segments.insert(expected_segments.size(), word);
   endtask

   // expected words for one accepted monomer
   task automatic rebin_monomer(input logic signed [ENERGY_W-1:0] energy, input logic last);
      longint e, m, seg, floor_len, pos;
      int     n;
      e = energy;
      m = mono_len;
      if (m == 0) m = 1;
      floor_len = (m + SPLIT_CAP - 1) / SPLIT_CAP;
      seg = seg_len;
      if (seg < floor_len) seg = floor_len;
      if (!chain_open) begin
         seg_end = seg;
         chain_open = 1'b1;
      end
      pos = 0;
      n = 0;
      // every segment that closes inside this monomer
      while (seg_end < m && n < SPLIT_CAP) begin
         add_share(e, seg_end - pos, m);
         push_segment(1'b0);
         n++;
         run_sum = 0;
         pos = seg_end;
         seg_end += seg;
      end
      if (pos < m) add_share(e, m - pos, m);
      seg_end = (seg_end >= m) ? seg_end - m : 0;
      seg_end &= OFFSET_MASK;
      // chain end flushes the open sum
      if (last) begin
         push_segment(1'b1);
         run_sum = 0;
         chain_open = 1'b0;
         seg_end = seg;
      end
   endtask

   task automatic queue_monomer(input logic signed [ENERGY_W-1:0] energy, input logic last);
      monomer_word_type word;
      word.energy     = energy;
      word.final_item = last;
      monomer_backlog.insert(monomer_backlog.size(), word);
   endtask

   function automatic logic signed [ENERGY_W-1:0] pick_energy();
      int v;
      case ($urandom_range(9))
         0: return ENERGY_MAX;
         1: return ENERGY_MIN;
         2, 3: begin
            v = $urandom_range(1 << 20);
            return v - (1 << 19);
         end
         default: return $urandom();
      endcase
   endfunction

   // wait until every word is through, then let a silent item finish
   task automatic drain();
      while (monomer_backlog.size() != 0 || req_if.valid || expected_segments.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input owsr_pkg::csr_reg_type index, input logic [LEN_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(index) << CSR_IDX_BIT;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == owsr_pkg::REG_MONOMER_LENGTH) mono_len = value;
      else seg_len = value;
   endtask

   task automatic set_lengths(input logic [LEN_W-1:0] mono, input logic [LEN_W-1:0] seg);
      drain();
      csr_write(owsr_pkg::REG_MONOMER_LENGTH, mono);
      csr_write(owsr_pkg::REG_SEGMENT_LENGTH, seg);
   endtask

   // input driver: presents the backlog, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (monomer_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 29)) begin
            req_if.valid      <= 1'b1;
            req_if.energy     <= monomer_backlog[0].energy;
            req_if.final_item <= monomer_backlog[0].final_item;
            void'(monomer_backlog.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= steady_flow || ($urandom_range(99) >= 29);
   end

   // monitor: check result words, predict from accepted input words
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_segments.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("unexpected word: segment_energy %0d final_result %0b",
                           rsp_if.segment_energy, rsp_if.final_result);
               mismatch_count++;
            end else begin
               oldest_segment = expected_segments.pop_front();
               if (oldest_segment.energy !== rsp_if.segment_energy ||
                   oldest_segment.final_result !== rsp_if.final_result) begin
                  if (mismatch_count < REPORT_MAX)
                     $display({"mismatch: segment_energy exp %0d got %0d, ",
                               "final_result exp %0b got %0b"},
                              oldest_segment.energy, rsp_if.segment_energy,
                              oldest_segment.final_result, rsp_if.final_result);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) rebin_monomer(req_if.energy, req_if.final_item);
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL overlap_weighted_segment_rebinner_top");
         $finish;
      end
   end

   initial begin
      logic [LEN_W-1:0] mono;
      logic [LEN_W-1:0] seg;
      longint           span;
      int               sel;
      bit               close_chain;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.energy     = '0;
      req_if.final_item = 1'b0;
      rsp_if.ready      = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset lengths (3.5 per monomer, 10.0 per segment): extremes, word saturation
      @(negedge clock);
      queue_monomer(ENERGY_MAX, 1'b0);
      queue_monomer(ENERGY_MAX, 1'b0);
      queue_monomer(ENERGY_MAX, 1'b0);
      queue_monomer(ENERGY_MIN, 1'b0);
      queue_monomer('0, 1'b0);
      queue_monomer(-1, 1'b0);
      queue_monomer(1, 1'b1);

      // segment of two monomers: segments end on monomer borders
      set_lengths(24'h010000, 24'h020000);
      @(negedge clock);
      queue_monomer(32'sh00030000, 1'b0);
      queue_monomer(-32'sh00010000, 1'b0);
      queue_monomer(32'sh00003039, 1'b0);
      queue_monomer(ENERGY_MAX, 1'b1);
      queue_monomer(ENERGY_MIN, 1'b1);

      // segment far below monomer/16: clamped, up to sixteen closings per monomer
      set_lengths(24'h100000, 24'h000001);
      @(negedge clock);
      queue_monomer(32'sh12345678, 1'b0);
      queue_monomer(ENERGY_MIN, 1'b1);

      // zero lengths
      set_lengths('0, '0);
      @(negedge clock);
      queue_monomer(ENERGY_MAX, 1'b0);
      queue_monomer(-32'sh00000007, 1'b0);
      queue_monomer(32'sh00000005, 1'b1);

      // largest lengths, then the segment length rewritten mid-chain
      set_lengths(LEN_MAX, LEN_MAX);
      @(negedge clock);
      queue_monomer(ENERGY_MAX, 1'b0);
      drain();
      csr_write(owsr_pkg::REG_SEGMENT_LENGTH, 24'h000001);
      @(negedge clock);
      queue_monomer(ENERGY_MIN, 1'b1);

      // random phases, each with its own lengths
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(7))
            0: mono = '0;
            1: mono = 24'h000001;
            2: mono = LEN_MAX;
            3, 4: mono = $urandom_range(1 << 15, 1 << 18);
            default: mono = $urandom_range(1, LEN_MAX);
         endcase
         sel = $urandom_range(7);
         case (sel)
            0: seg = $urandom_range(mono / SPLIT_CAP);
            1: seg = LEN_MAX;
            default: begin
               // mostly longer than a monomer; exact multiples hit borders
               span = longint'(mono) * $urandom_range(1, 6)
                      + ((sel == 2) ? 0 : $urandom_range(mono));
               seg = (span > LEN_MAX) ? LEN_MAX : span[LEN_W-1:0];
            end
         endcase
         set_lengths(mono, seg);
         close_chain = $urandom_range(1);
         @(negedge clock);
         steady_flow = (phase == STEADY_PHASE);
         for (int k = 0; k < PHASE_ITEMS; k++)
            queue_monomer(pick_energy(),
                          (close_chain && k == PHASE_ITEMS - 1) || $urandom_range(7) == 0);
      end

      drain();
      if (mismatch_count == 0 && expected_segments.size() == 0)
         $display("PASS overlap_weighted_segment_rebinner_top");
      else
         $display("FAIL overlap_weighted_segment_rebinner_top");
      $finish;
   end

endmodule

// ===== overlap_weighted_segment_rebinner_top.f =====
sv/owsr_pkg.sv
sv/owsr_if.sv
sv/owsr_div.sv
sv/owsr_csr.sv
sv/owsr_ctrl.sv
sv/owsr_dp.sv
sv/overlap_weighted_segment_rebinner_top.sv
tb/overlap_weighted_segment_rebinner_top_test.sv
